/* design/pcfc_pkg.sv */
package pcfc_pkg;

  localparam int NUM_CPUS = 8;
  localparam int MAX_CPUS = 8;

  localparam int KHZ_W = 22;
  localparam int MW_W = 14;
  localparam int CPU_MW_W = 11;

  typedef logic [KHZ_W-1:0] khz_t;
  typedef logic [MW_W-1:0] mw_t;
  typedef logic [CPU_MW_W-1:0] cpu_mw_t;

  typedef enum logic [2:0] {
    DEC_DISABLED = 3'd0,
    DEC_OVERRIDE = 3'd1,
    DEC_HELD     = 3'd2,
    DEC_CLAMPED  = 3'd3,
    DEC_CAPPED   = 3'd4
  } decision_t;

  typedef enum logic [2:0] {
    CFG_ENABLE      = 3'd0,
    CFG_POWER_LIMIT = 3'd1,
    CFG_OVERRIDE    = 3'd2,
    CFG_HOLD        = 3'd3,
    CFG_CLAMP       = 3'd4,
    CFG_CAP         = 3'd5
  } cfg_index_t;

  localparam logic   RST_ENABLE      = 1'b1;
  localparam mw_t    RST_POWER_LIMIT = MW_W'(2100);
  localparam mw_t    RST_OVERRIDE    = MW_W'(4000);
  localparam mw_t    RST_HOLD        = MW_W'(10000);
  localparam khz_t   RST_CLAMP       = KHZ_W'(600000);
  localparam khz_t   RST_CAP         = KHZ_W'(1200000);

  localparam khz_t   STEP0_KHZ = KHZ_W'(600000);
  localparam khz_t   STEP1_KHZ = KHZ_W'(900000);
  localparam khz_t   STEP2_KHZ = KHZ_W'(1200000);
  localparam khz_t   STEP3_KHZ = KHZ_W'(1500000);

  localparam cpu_mw_t LEVEL0_MW = CPU_MW_W'(150);
  localparam cpu_mw_t LEVEL1_MW = CPU_MW_W'(350);
  localparam cpu_mw_t LEVEL2_MW = CPU_MW_W'(700);
  localparam cpu_mw_t LEVEL3_MW = CPU_MW_W'(1100);
  localparam cpu_mw_t LEVEL4_MW = CPU_MW_W'(1400);

  localparam mw_t MAX_POWER_MW = MW_W'(NUM_CPUS * 1400);

  function automatic cpu_mw_t cpu_power(input khz_t f);
    cpu_mw_t p;
    if (f <= STEP0_KHZ) begin
      p = LEVEL0_MW;
    end else if (f <= STEP1_KHZ) begin
      p = LEVEL1_MW;
    end else if (f <= STEP2_KHZ) begin
      p = LEVEL2_MW;
    end else if (f <= STEP3_KHZ) begin
      p = LEVEL3_MW;
    end else begin
      p = LEVEL4_MW;
    end
    return p;
  endfunction

endpackage

/* design/power_cap_frequency_clamp.sv */
// channel | valid        | stall        | payload
// item    | item_valid   | item_stall   | kind, request_khz, online_mask, freq_cpu0..7
// result  | result_valid | result_stall | decided_khz, power_mw, decision
// config  | cfg_write    | -            | cfg_index, cfg_data
//
// one word per cycle in while item_stall is low; a request goes from the input register into the result register
// the rate is set by the input register and result register
// a tick word gives no result and only moves the hold window down
// result_stall holds the result register; the input register still drains ticks
// rst is synchronous and restores the register defaults and clears the lock
module power_cap_frequency_clamp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [2:0]              cfg_index,
  input  logic [21:0]             cfg_data,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic                    kind,
  input  logic [21:0]             request_khz,
  input  logic [7:0]              online_mask,
  input  logic [21:0]             freq_cpu0,
  input  logic [21:0]             freq_cpu1,
  input  logic [21:0]             freq_cpu2,
  input  logic [21:0]             freq_cpu3,
  input  logic [21:0]             freq_cpu4,
  input  logic [21:0]             freq_cpu5,
  input  logic [21:0]             freq_cpu6,
  input  logic [21:0]             freq_cpu7,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [21:0]             decided_khz,
  output logic [13:0]             power_mw,
  output logic [2:0]              decision
);

  logic             enable;
  pcfc_pkg::mw_t    power_limit_mw;
  pcfc_pkg::mw_t    override_mw;
  pcfc_pkg::mw_t    hold_ms;
  pcfc_pkg::khz_t   clamp_khz;
  pcfc_pkg::khz_t   cap_khz;

  pcfc_pkg::khz_t   locked_khz;
  pcfc_pkg::khz_t   locked_khz_next;
  pcfc_pkg::mw_t    hold_countdown;
  pcfc_pkg::mw_t    hold_countdown_next;

  logic             s1_valid;
  logic             s1_kind;
  pcfc_pkg::khz_t   s1_request;
  logic [7:0]       s1_mask;
  pcfc_pkg::khz_t   s1_freq [pcfc_pkg::MAX_CPUS];
  pcfc_pkg::khz_t   in_freq [pcfc_pkg::MAX_CPUS];

  logic             accept;
  logic             s1_move;
  logic             out_take;

  pcfc_pkg::mw_t        cpu_mw [pcfc_pkg::MAX_CPUS];
  pcfc_pkg::mw_t        power_sum;
  pcfc_pkg::khz_t       target_next;
  pcfc_pkg::decision_t  decision_next;

  assign in_freq[0] = freq_cpu0;
  assign in_freq[1] = freq_cpu1;
  assign in_freq[2] = freq_cpu2;
  assign in_freq[3] = freq_cpu3;
  assign in_freq[4] = freq_cpu4;
  assign in_freq[5] = freq_cpu5;
  assign in_freq[6] = freq_cpu6;
  assign in_freq[7] = freq_cpu7;

  assign out_take   = result_valid && !result_stall;
  assign s1_move    = s1_valid && (!s1_kind || !result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_move;
  assign accept     = item_valid && !item_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= pcfc_pkg::RST_ENABLE;
      power_limit_mw <= pcfc_pkg::RST_POWER_LIMIT;
      override_mw    <= pcfc_pkg::RST_OVERRIDE;
      hold_ms        <= pcfc_pkg::RST_HOLD;
      clamp_khz      <= pcfc_pkg::RST_CLAMP;
      cap_khz        <= pcfc_pkg::RST_CAP;
    end else if (cfg_write) begin
      case (cfg_index)
        pcfc_pkg::CFG_ENABLE:      enable         <= cfg_data[0];
        pcfc_pkg::CFG_POWER_LIMIT: power_limit_mw <= cfg_data[pcfc_pkg::MW_W-1:0];
        pcfc_pkg::CFG_OVERRIDE:    override_mw    <= cfg_data[pcfc_pkg::MW_W-1:0];
        pcfc_pkg::CFG_HOLD:        hold_ms        <= cfg_data[pcfc_pkg::MW_W-1:0];
        pcfc_pkg::CFG_CLAMP:       clamp_khz      <= cfg_data;
        pcfc_pkg::CFG_CAP:         cap_khz        <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind    <= kind;
      s1_request <= request_khz;
      s1_mask    <= online_mask;
      s1_freq    <= in_freq;
    end
  end

  // power estimate
  always_comb begin
    for (int i = 0; i < pcfc_pkg::MAX_CPUS; i++) begin
      cpu_mw[i] = '0;
      if (i < pcfc_pkg::NUM_CPUS && s1_mask[i]) begin
        cpu_mw[i] = pcfc_pkg::MW_W'(pcfc_pkg::cpu_power(s1_freq[i]));
      end
    end
    power_sum = ((cpu_mw[0] + cpu_mw[1]) + (cpu_mw[2] + cpu_mw[3]))
              + ((cpu_mw[4] + cpu_mw[5]) + (cpu_mw[6] + cpu_mw[7]));
  end

  // decision and window state
  always_comb begin
    locked_khz_next     = locked_khz;
    hold_countdown_next = hold_countdown;
    target_next         = s1_request;
    decision_next       = pcfc_pkg::DEC_DISABLED;
    if (!s1_kind) begin
      if (hold_countdown != '0) begin
        hold_countdown_next = hold_countdown - pcfc_pkg::MW_W'(1);
      end
    end else if (!enable) begin
      decision_next = pcfc_pkg::DEC_DISABLED;
    end else if (power_sum >= override_mw) begin
      locked_khz_next     = '0;
      hold_countdown_next = hold_ms;
      decision_next       = pcfc_pkg::DEC_OVERRIDE;
    end else if (hold_countdown != '0) begin
      if (locked_khz != '0) begin
        target_next = locked_khz;
      end
      decision_next = pcfc_pkg::DEC_HELD;
    end else if (power_sum > power_limit_mw) begin
      locked_khz_next     = clamp_khz;
      hold_countdown_next = hold_ms;
      target_next         = clamp_khz;
      decision_next       = pcfc_pkg::DEC_CLAMPED;
    end else begin
      locked_khz_next     = '0;
      hold_countdown_next = hold_ms;
      if (s1_request > cap_khz) begin
        target_next = cap_khz;
      end
      decision_next = pcfc_pkg::DEC_CAPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locked_khz     <= '0;
      hold_countdown <= '0;
    end else if (s1_move) begin
      locked_khz     <= locked_khz_next;
      hold_countdown <= hold_countdown_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move && s1_kind) begin
      result_valid <= 1'b1;
    end else if (out_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_kind) begin
      decided_khz <= target_next;
      power_mw    <= power_sum;
      decision    <= decision_next;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (decision == pcfc_pkg::DEC_DISABLED || decision == pcfc_pkg::DEC_OVERRIDE
      || decision == pcfc_pkg::DEC_HELD || decision == pcfc_pkg::DEC_CLAMPED
      || decision == pcfc_pkg::DEC_CAPPED))
    else $error("result decision code out of range");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> power_mw <= pcfc_pkg::MAX_POWER_MW)
    else $error("power estimate above the maximum for all cpus");

  assert property (@(posedge clk) disable iff (rst)
    (s1_move && !s1_kind && hold_countdown != '0)
    |=> hold_countdown == $past(hold_countdown) - pcfc_pkg::MW_W'(1))
    else $error("tick did not move the hold window down");

  assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1_kind && decision_next == pcfc_pkg::DEC_CLAMPED)
    |=> locked_khz == $past(clamp_khz) && hold_countdown == $past(hold_ms)
        && result_valid && decided_khz == locked_khz)
    else $error("clamp not locked with its window");

  assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1_kind && decision_next == pcfc_pkg::DEC_DISABLED)
    |=> $stable(locked_khz) && $stable(hold_countdown))
    else $error("disabled request changed the window state");
`endif

endmodule
